[design/sitda_pkg.sv]
// Shared constants and helpers for the signed integer to decimal ASCII converter.
// No dependencies; imported by every module of the block.
package sitda_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 64;
    localparam int VALUE_BITS          = 64;
    localparam int CHAR_BITS           = 7;
    localparam int QUEUE_DEPTH         = 2;

    localparam int RADIX = 10;

    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE  = CHAR_ZERO + CHAR_BITS'(RADIX - 1);

    // Double-dabble correction: a BCD digit at or above half the radix gets
    // the adjustment added before the next shift.
    localparam logic [3:0] DD_THRESH = 4'(RADIX / 2);
    localparam logic [3:0] DD_ADJ    = 4'((16 - RADIX) / 2);

    // Number of decimal digits needed for any unsigned value of w bits.
    // 1233/4096 is just below log10(2); the shortfall is too small to change
    // the count for any width up to 64.
    function automatic int f_num_digits(input int w);
        return ((w * 1233) >> 12) + 1;
    endfunction

endpackage

[design/signed_int_to_decimal_ascii.sv]
// Top level of the signed integer to decimal ASCII converter.
// Instantiates sitda_front, sitda_queue and sitda_back; depends on sitda_pkg.
//
// Usage: one input transaction on i_valid/o_stall carries a signed integer in
// i_value; only its low VALUE_WIDTH bits are used and bit VALUE_WIDTH-1 is the
// sign. The block answers with one output transaction per character on
// o_valid/i_stall: an optional '-' followed by the decimal digits, most
// significant first, with o_last_char set on the final digit. Zero gives the
// single character "0"; the most negative value is printed from its full
// magnitude.
// Timing: the front stage registers sign and magnitude and hands them through
// a two-entry queue. The back engine converts by shift-and-adjust, one
// magnitude bit per cycle, then emits a minus sign for a negative value and
// walks all decimal digit positions (20 at width 64), one per cycle unless a
// character waits on a stalled output, skipping leading zeros. The engine
// takes no new integer until it has finished the previous one.
// A stall from the receiver holds the output register and pauses character
// emission only; the front stage and queue keep taking new integers until the
// queue fills. Reset clears all control state; no item is in flight after it.
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CHAR_BITS-1:0]  o_char_code,
    output logic                  o_last_char
);

    // Sign bit on top of the magnitude.
    logic                 front_valid;
    logic                 front_stall;
    logic [VALUE_WIDTH:0] front_data;
    logic                 queue_valid;
    logic                 queue_stall;
    logic [VALUE_WIDTH:0] queue_data;

    sitda_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .o_valid (front_valid),
        .i_stall (front_stall),
        .o_data  (front_data)
    );

    sitda_queue #(
        .DATA_WIDTH (VALUE_WIDTH + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_stall (front_stall),
        .i_data  (front_data),
        .o_valid (queue_valid),
        .i_stall (queue_stall),
        .o_data  (queue_data)
    );

    // The engine takes a new entry only when it has finished the previous one.
    sitda_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .o_stall     (queue_stall),
        .i_data      (queue_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule

[design/sitda_front.sv]
// Front stage: accepts an integer, takes its sign and magnitude and registers them.
// Depends on sitda_pkg.
module sitda_front
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [VALUE_BITS-1:0]  i_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [VALUE_WIDTH:0]   o_data
);

    logic                   r_valid;
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] v;
    logic                   n_neg;
    logic [VALUE_WIDTH-1:0] n_mag;
    logic                   accept;

    // Bits above the configured width are ignored. The most negative value
    // negates to itself, which read unsigned is exactly its magnitude.
    always_comb begin
        v     = i_value[VALUE_WIDTH-1:0];
        n_neg = v[VALUE_WIDTH-1];
        n_mag = n_neg ? (~v + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v;
    end

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_data  = {r_neg, r_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= n_neg;
            r_mag <= n_mag;
        end
    end

endmodule

[design/sitda_queue.sv]
// Short queue between the front stage and the conversion engine.
// Depends on sitda_pkg for its depth.
module sitda_queue
    import sitda_pkg::*;
#(
    parameter int DATA_WIDTH = DEFAULT_VALUE_WIDTH + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [DATA_WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [CNT_W-1:0]      r_count;
    logic                  push;
    logic                  pop;

    assign o_stall = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/sitda_back.sv]
// Conversion engine: bit-serial double-dabble to BCD, then character emission
// through an output register. Depends on sitda_pkg.
module sitda_back
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [VALUE_WIDTH:0] i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [CHAR_BITS-1:0] o_char_code,
    output logic                 o_last_char
);

    localparam int NDIG   = f_num_digits(VALUE_WIDTH);
    localparam int BCD_W  = 4 * NDIG;
    localparam int CNT_W  = $clog2(VALUE_WIDTH);
    localparam int DIDX_W = $clog2(NDIG);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_SIGN  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [1:0]             r_state, n_state;
    logic                   r_neg, n_neg;
    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [DIDX_W-1:0]      r_didx, n_didx;
    logic                   r_started, n_started;
    logic                   r_out_valid, n_out_valid;
    logic [CHAR_BITS-1:0]   r_char, n_char;
    logic                   r_last, n_last;

    logic [BCD_W-1:0] bcd_adj;
    logic [3:0]       top_digit;
    logic             out_free;
    logic             emit;

    function automatic logic f_bcd_ok(input logic [BCD_W-1:0] b);
        logic ok;
        ok = 1'b1;
        for (int d = 0; d < NDIG; d++) begin
            if (b[d*4 +: 4] > 4'(RADIX - 1)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // Every digit is corrected on its own before the shift.
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            bcd_adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= DD_THRESH) ?
                                (r_bcd[d*4 +: 4] + DD_ADJ) : r_bcd[d*4 +: 4];
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: 4];
    assign out_free  = !r_out_valid || !i_stall;
    assign emit      = r_started || (top_digit != 4'd0) || (r_didx == '0);
    assign o_stall   = (r_state != ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_didx      = r_didx;
        n_started   = r_started;
        n_out_valid = r_out_valid && i_stall;
        n_char      = r_char;
        n_last      = r_last;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_neg   = i_data[VALUE_WIDTH];
                    n_bin   = i_data[VALUE_WIDTH-1:0];
                    n_bcd   = '0;
                    n_cnt   = CNT_W'(VALUE_WIDTH - 1);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = {bcd_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_didx    = DIDX_W'(NDIG - 1);
                    n_started = 1'b0;
                    n_state   = r_neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_MINUS;
                    n_last      = 1'b0;
                    n_state     = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (!emit || out_free) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_didx = r_didx - 1'b1;
                    if (emit) begin
                        n_out_valid = 1'b1;
                        n_char      = CHAR_ZERO + {3'd0, top_digit};
                        n_last      = (r_didx == '0);
                        n_started   = 1'b1;
                    end
                    if (r_didx == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg     <= n_neg;
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_cnt     <= n_cnt;
        r_didx    <= n_didx;
        r_started <= n_started;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV || r_state == ST_DIGIT) |-> f_bcd_ok(r_bcd))
        else $error("BCD digit out of range during conversion");

    a_sign_only_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIGN) |-> r_neg)
        else $error("sign state entered for a non-negative value");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_char == CHAR_MINUS || (r_char >= CHAR_ZERO && r_char <= CHAR_NINE)))
        else $error("emitted character is neither minus nor digit");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_char == CHAR_MINUS) |-> !r_last)
        else $error("minus sign flagged as last character");

    a_last_ends_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIGIT && n_out_valid && n_last && out_free) |=> (r_state == ST_IDLE))
        else $error("engine kept running after the last character");

endmodule
